// File: src/bclb_pkg.sv
// Shared types and constants for the bucket chain link builder.
`default_nettype none
package bclb_pkg;

  localparam int unsigned MAX_GROUPS = 1024;
  localparam int unsigned MAX_ITEMS  = 4096;

  localparam int unsigned GROUP_REF_W = 10;
  localparam int unsigned ITEM_REF_W  = 12;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned CFG_W       = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LINK   = 2'd2,
    OP_HEAD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    op_e                    opcode;
    logic [GROUP_REF_W-1:0] group_ref;
    logic [ITEM_REF_W-1:0]  item_ref;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [ITEM_REF_W-1:0] item_index;
    logic                  item_valid;
    logic [ITEM_REF_W-1:0] prev_index;
    logic                  prev_valid;
    logic [COUNT_W-1:0]    group_count;
    logic [ITEM_REF_W-1:0] link_index;
    logic                  link_valid;
  } rsp_t;

endpackage
`default_nettype wire

// File: src/bclb_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module bclb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: src/bclb_seq.sv
// Sequencer and datapath around the group row and next-link memories.
`default_nettype none
module bclb_seq #(
  parameter int unsigned MAX_GROUPS = bclb_pkg::MAX_GROUPS,
  parameter int unsigned MAX_ITEMS  = bclb_pkg::MAX_ITEMS,
  localparam int unsigned GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
  localparam int unsigned IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1),
  localparam int unsigned RW = CW + 2 * IW
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire bclb_pkg::req_t             req_i,
  output logic                            done_o,
  output bclb_pkg::rsp_t                  rsp_o,
  input  wire logic [bclb_pkg::CFG_W-1:0] groups_in_use_i,
  output logic                            grp_we_o,
  output logic      [GW-1:0]              grp_waddr_o,
  output logic      [RW-1:0]              grp_wdata_o,
  output logic      [GW-1:0]              grp_raddr_o,
  input  wire logic [RW-1:0]              grp_rdata_i,
  output logic                            lnk_we_o,
  output logic      [IW-1:0]              lnk_waddr_o,
  output logic      [IW:0]                lnk_wdata_o,
  output logic      [IW-1:0]              lnk_raddr_o,
  input  wire logic [IW:0]                lnk_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_GRP,
    S_HEAD,
    S_LINK
  } state_e;

  state_e         state_q;
  logic [GW-1:0]  sweep_q;
  logic           report_q;
  logic [CW-1:0]  fill_q;
  logic [GW-1:0]  gaddr_q;
  logic           link_ok_q;
  logic           done_q;
  bclb_pkg::rsp_t rsp_q;

  logic           accept;
  logic [31:0]    g_ext;
  logic [31:0]    it_ext;
  logic           g_ok;
  logic           it_ok;
  logic           full;
  logic [IW-1:0]  idx;
  logic [CW-1:0]  size_r;
  logic [IW-1:0]  tail_r;
  logic [IW-1:0]  head_r;
  logic [CW-1:0]  size_n;
  logic [IW-1:0]  head_n;
  bclb_pkg::rsp_t rsp_err;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign g_ext  = 32'(req_i.group_ref);
  assign it_ext = 32'(req_i.item_ref);
  assign g_ok   = (g_ext < 32'(groups_in_use_i)) && (g_ext < 32'(MAX_GROUPS));
  assign it_ok  = (it_ext < 32'(fill_q)) && (it_ext < 32'(MAX_ITEMS));
  assign full   = (fill_q == CW'(MAX_ITEMS));
  assign idx    = IW'(fill_q);

  assign size_r = grp_rdata_i[RW-1 -: CW];
  assign tail_r = grp_rdata_i[2*IW-1:IW];
  assign head_r = grp_rdata_i[IW-1:0];
  assign size_n = size_r + CW'(1);
  assign head_n = (size_r == '0) ? idx : head_r;

  assign grp_raddr_o = GW'(g_ext);
  assign lnk_raddr_o = IW'(it_ext);

  always_comb begin
    rsp_err = '0;
    if (g_ok) begin
      rsp_err.status = bclb_pkg::ST_FULL;
    end else begin
      rsp_err.status = bclb_pkg::ST_RANGE;
    end
  end

  always_comb begin
    grp_we_o    = 1'b0;
    grp_waddr_o = gaddr_q;
    grp_wdata_o = {size_n, idx, head_n};
    lnk_we_o    = 1'b0;
    lnk_waddr_o = idx;
    lnk_wdata_o = '0;
    case (state_q)
      S_SWEEP: begin
        grp_we_o    = 1'b1;
        grp_waddr_o = sweep_q;
        grp_wdata_o = '0;
      end
      S_GRP: begin
        grp_we_o    = 1'b1;
        lnk_we_o    = (size_r != '0);
        lnk_waddr_o = tail_r;
        lnk_wdata_o = {1'b1, idx};
      end
      S_IDLE: begin
        lnk_we_o = accept && (req_i.opcode == bclb_pkg::OP_APPEND) && g_ok && !full;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SWEEP;
      sweep_q   <= '0;
      report_q  <= 1'b0;
      fill_q    <= '0;
      gaddr_q   <= '0;
      link_ok_q <= 1'b0;
      done_q    <= 1'b0;
      rsp_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            gaddr_q   <= GW'(g_ext);
            link_ok_q <= it_ok;
            case (req_i.opcode)
              bclb_pkg::OP_CLEAR: begin
                state_q  <= S_SWEEP;
                sweep_q  <= '0;
                report_q <= 1'b1;
                fill_q   <= '0;
                rsp_q    <= '0;
              end
              bclb_pkg::OP_APPEND: begin
                if (!g_ok || full) begin
                  done_q <= 1'b1;
                  rsp_q  <= rsp_err;
                end else begin
                  state_q <= S_GRP;
                  rsp_q   <= '0;
                end
              end
              bclb_pkg::OP_LINK: begin
                state_q <= S_LINK;
                rsp_q   <= '0;
              end
              default: begin
                if (!g_ok) begin
                  done_q <= 1'b1;
                  rsp_q  <= rsp_err;
                end else begin
                  state_q <= S_HEAD;
                  rsp_q   <= '0;
                end
              end
            endcase
          end
        end
        S_SWEEP: begin
          sweep_q <= sweep_q + GW'(1);
          if (sweep_q == GW'(MAX_GROUPS - 1)) begin
            state_q <= S_IDLE;
            done_q  <= report_q;
            rsp_q   <= '0;
          end
        end
        S_GRP: begin
          state_q           <= S_IDLE;
          done_q            <= 1'b1;
          fill_q            <= fill_q + CW'(1);
          rsp_q.status      <= bclb_pkg::ST_OK;
          rsp_q.item_index  <= bclb_pkg::ITEM_REF_W'(idx);
          rsp_q.item_valid  <= 1'b1;
          rsp_q.prev_index  <= (size_r != '0) ? bclb_pkg::ITEM_REF_W'(tail_r) : '0;
          rsp_q.prev_valid  <= (size_r != '0);
          rsp_q.group_count <= bclb_pkg::COUNT_W'(size_n);
        end
        S_HEAD: begin
          state_q           <= S_IDLE;
          done_q            <= 1'b1;
          rsp_q.status      <= bclb_pkg::ST_OK;
          rsp_q.group_count <= bclb_pkg::COUNT_W'(size_r);
          rsp_q.item_valid  <= (size_r != '0);
          rsp_q.item_index  <= (size_r != '0) ? bclb_pkg::ITEM_REF_W'(head_r) : '0;
        end
        S_LINK: begin
          state_q          <= S_IDLE;
          done_q           <= 1'b1;
          rsp_q.status     <= bclb_pkg::ST_OK;
          rsp_q.link_valid <= link_ok_q && lnk_rdata_i[IW];
          rsp_q.link_index <= (link_ok_q && lnk_rdata_i[IW]) ?
                              bclb_pkg::ITEM_REF_W'(lnk_rdata_i[IW-1:0]) : '0;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(MAX_ITEMS))
    else $error("fill count beyond item capacity");

  a_grp_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GRP) |=> (done_q && rsp_q.status == bclb_pkg::ST_OK && rsp_q.item_valid))
    else $error("append did not report its item");

  a_tail_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GRP && size_r != '0) |-> (32'(tail_r) < 32'(fill_q)))
    else $error("chain tail names an item not yet appended");

  a_sweep_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && sweep_q != GW'(MAX_GROUPS - 1)) |=> !done_q)
    else $error("result strobed in the middle of a clear sweep");

  a_link_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |=> (done_q && !rsp_q.item_valid && !rsp_q.prev_valid))
    else $error("link read result malformed");

endmodule
`default_nettype wire

// File: src/bucket_chain_link_builder.sv
// Top level of the bucket chain link builder: config register, memories, sequencer.
`default_nettype none
// A request is taken when start_i is high and busy_o is low. Append, next-link read
// and group-head read each do one registered read of the group row or link memory,
// then the result and, for append, the write-back. A group out of range or a full
// item table answers in the cycle after the request. Clear, and the pass after
// reset, sweep all MAX_GROUPS rows (1024 by default) of the group memory one row a
// cycle with busy_o high; reset produces no result. Each result sits on rsp_o with
// done_o high for one cycle and cannot be held off by the receiver. The user must
// write groups_in_use via cfg_we_i/cfg_data_i only while idle, unchecked by the block.
module bucket_chain_link_builder #(
  parameter int unsigned MAX_GROUPS = bclb_pkg::MAX_GROUPS,
  parameter int unsigned MAX_ITEMS  = bclb_pkg::MAX_ITEMS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire bclb_pkg::req_t             req_i,
  output logic                            done_o,
  output bclb_pkg::rsp_t                  rsp_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [bclb_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int unsigned GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned RW = CW + 2 * IW;

  logic [bclb_pkg::CFG_W-1:0] groups_q;

  logic          grp_we;
  logic [GW-1:0] grp_waddr;
  logic [RW-1:0] grp_wdata;
  logic [GW-1:0] grp_raddr;
  logic [RW-1:0] grp_rdata;
  logic          lnk_we;
  logic [IW-1:0] lnk_waddr;
  logic [IW:0]   lnk_wdata;
  logic [IW-1:0] lnk_raddr;
  logic [IW:0]   lnk_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_q <= bclb_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      groups_q <= cfg_data_i;
    end
  end

  bclb_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_GROUPS)
  ) u_grp_ram (
    .clk_i   (clk_i),
    .we_i    (grp_we),
    .waddr_i (grp_waddr),
    .wdata_i (grp_wdata),
    .raddr_i (grp_raddr),
    .rdata_o (grp_rdata)
  );

  bclb_ram #(
    .WIDTH (IW + 1),
    .DEPTH (MAX_ITEMS)
  ) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .raddr_i (lnk_raddr),
    .rdata_o (lnk_rdata)
  );

  bclb_seq #(
    .MAX_GROUPS (MAX_GROUPS),
    .MAX_ITEMS  (MAX_ITEMS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .req_i           (req_i),
    .done_o          (done_o),
    .rsp_o           (rsp_o),
    .groups_in_use_i (groups_q),
    .grp_we_o        (grp_we),
    .grp_waddr_o     (grp_waddr),
    .grp_wdata_o     (grp_wdata),
    .grp_raddr_o     (grp_raddr),
    .grp_rdata_i     (grp_rdata),
    .lnk_we_o        (lnk_we),
    .lnk_waddr_o     (lnk_waddr),
    .lnk_wdata_o     (lnk_wdata),
    .lnk_raddr_o     (lnk_raddr),
    .lnk_rdata_i     (lnk_rdata)
  );

endmodule
`default_nettype wire

// File: tb/sv/bclb_chain_checker.sv
// Checker for the bucket chain link builder: tracks the chains and compares every result.
module bclb_chain_checker
  import bclb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  req_t              req_i,
  input  logic              done_i,
  input  rsp_t              rsp_i,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output int unsigned       fault_count_o,
  output int unsigned       pending_o
);

  logic [CFG_W-1:0]      groups_in_use;
  logic [ITEM_REF_W-1:0] head_mem [MAX_GROUPS];
  logic [ITEM_REF_W-1:0] tail_mem [MAX_GROUPS];
  logic [COUNT_W-1:0]    size_mem [MAX_GROUPS];
  logic [ITEM_REF_W-1:0] link_mem [MAX_ITEMS];
  bit                    link_set [MAX_ITEMS];
  logic [COUNT_W-1:0]    fill_count;
  rsp_t                  chain_answers [$];
  int unsigned           shown;

  function automatic rsp_t chain_request(req_t r);
    rsp_t                  a;
    logic [ITEM_REF_W-1:0] idx;
    logic [ITEM_REF_W-1:0] tail;
    logic                  in_range;
    int                    g;
    a = '0;
    in_range = (r.group_ref < groups_in_use) && (r.group_ref < MAX_GROUPS);
    case (r.opcode)
      OP_CLEAR: begin
        for (g = 0; g < MAX_GROUPS; g++) size_mem[g] = '0;
        fill_count = '0;
      end
      OP_APPEND: begin
        if (!in_range) begin
          a.status = ST_RANGE;
        end else if (fill_count >= MAX_ITEMS) begin
          a.status = ST_FULL;
        end else begin
          idx = fill_count[ITEM_REF_W-1:0];
          link_set[idx] = 1'b0;
          if (size_mem[r.group_ref] == '0) begin
            head_mem[r.group_ref] = idx;
            size_mem[r.group_ref] = COUNT_W'(1);
          end else begin
            tail = tail_mem[r.group_ref];
            link_mem[tail] = idx;
            link_set[tail] = 1'b1;
            a.prev_index = tail;
            a.prev_valid = 1'b1;
            size_mem[r.group_ref] = size_mem[r.group_ref] + 1'b1;
          end
          tail_mem[r.group_ref] = idx;
          fill_count = fill_count + 1'b1;
          a.item_index = idx;
          a.item_valid = 1'b1;
          a.group_count = size_mem[r.group_ref];
        end
      end
      OP_LINK: begin
        if (r.item_ref < fill_count && link_set[r.item_ref]) begin
          a.link_index = link_mem[r.item_ref];
          a.link_valid = 1'b1;
        end
      end
      default: begin
        if (!in_range) begin
          a.status = ST_RANGE;
        end else begin
          a.group_count = size_mem[r.group_ref];
          if (size_mem[r.group_ref] != '0) begin
            a.item_index = head_mem[r.group_ref];
            a.item_valid = 1'b1;
          end
        end
      end
    endcase
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rsp_t exp;
    logic bad;
    int   g;
    if (!rst_ni) begin
      groups_in_use = CFG_RESET;
      for (g = 0; g < MAX_GROUPS; g++) size_mem[g] = '0;
      for (g = 0; g < MAX_ITEMS; g++) link_set[g] = 1'b0;
      fill_count = '0;
      chain_answers.delete();
      fault_count_o = 0;
      pending_o = 0;
      shown = 0;
    end else begin
      if (done_i) begin
        if (chain_answers.size() == 0) begin
          fault_count_o++;
          if (shown < 10) begin
            shown++;
            $display("chain check: result with no request pending, got %p", rsp_i);
          end
        end else begin
          exp = chain_answers.pop_front();
          bad = (rsp_i.status !== exp.status) ||
                (rsp_i.item_index !== exp.item_index) ||
                (rsp_i.item_valid !== exp.item_valid) ||
                (rsp_i.prev_index !== exp.prev_index) ||
                (rsp_i.prev_valid !== exp.prev_valid) ||
                (rsp_i.group_count !== exp.group_count) ||
                (rsp_i.link_index !== exp.link_index) ||
                (rsp_i.link_valid !== exp.link_valid);
          if (bad) begin
            fault_count_o++;
            if (shown < 10) begin
              shown++;
              $display("chain check: expected st=%0d idx=%0d/%0b prev=%0d/%0b cnt=%0d link=%0d/%0b",
                       exp.status, exp.item_index, exp.item_valid, exp.prev_index,
                       exp.prev_valid, exp.group_count, exp.link_index, exp.link_valid);
              $display("chain check: actual   st=%0d idx=%0d/%0b prev=%0d/%0b cnt=%0d link=%0d/%0b",
                       rsp_i.status, rsp_i.item_index, rsp_i.item_valid, rsp_i.prev_index,
                       rsp_i.prev_valid, rsp_i.group_count, rsp_i.link_index,
                       rsp_i.link_valid);
            end
          end
        end
      end
      if (cfg_we_i) groups_in_use = cfg_data_i;
      if (start_i && !busy_i) chain_answers.push_back(chain_request(req_i));
      pending_o = chain_answers.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
// Top of the bucket chain link builder testbench: clock, reset, request stimulus and verdict.
module testbench;
  import bclb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 800_000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  req_t             req = '0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = CFG_RESET;
  logic             busy;
  logic             done;
  rsp_t             rsp;
  int unsigned      fault_count;
  int unsigned      pending;

  int unsigned      burst_left = 0;
  int unsigned      cfg_now = CFG_RESET;
  int unsigned      appended = 0;
  int unsigned      clears_left = 4;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bucket_chain_link_builder DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_o     (busy),
    .req_i      (req),
    .done_o     (done),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  bclb_chain_checker chain_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req),
    .done_i        (done),
    .rsp_i         (rsp),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .fault_count_o (fault_count),
    .pending_o     (pending)
  );

  task automatic send_request(input op_e op, input int unsigned grp, input int unsigned itm);
    int unsigned gap;
    req_t        r;
    r = '0;
    r.opcode = op;
    r.group_ref = grp[GROUP_REF_W-1:0];
    r.item_ref = itm[ITEM_REF_W-1:0];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    if (op == OP_CLEAR) begin
      appended = 0;
    end else if (op == OP_APPEND && r.group_ref < cfg_now && appended < MAX_ITEMS) begin
      appended++;
    end
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_groups(input int unsigned value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_now = value[CFG_W-1:0];
  endtask

  task automatic random_request;
    int unsigned sel;
    int unsigned grp;
    int unsigned itm;
    op_e         op;
    sel = $urandom_range(0, 99);
    if (sel < 2 && clears_left > 0) begin
      op = OP_CLEAR;
      clears_left--;
    end else if (sel < 55) begin
      op = OP_APPEND;
    end else if (sel < 77) begin
      op = OP_LINK;
    end else begin
      op = OP_HEAD;
    end
    if ($urandom_range(0, 9) < 8 && cfg_now > 0) begin
      grp = $urandom_range(0, (cfg_now > MAX_GROUPS ? MAX_GROUPS : cfg_now) - 1);
    end else begin
      grp = $urandom_range(0, MAX_GROUPS - 1);
    end
    if ($urandom_range(0, 9) < 8) begin
      itm = $urandom_range(0, appended > MAX_ITEMS - 1 ? MAX_ITEMS - 1 : appended);
    end else begin
      itm = $urandom_range(0, MAX_ITEMS - 1);
    end
    send_request(op, grp, itm);
  endtask

  initial begin
    #(CYCLE_LIMIT * 12);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int unsigned n;
    int unsigned phase;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_groups(1024);
    send_request(OP_HEAD, 0, 0);
    send_request(OP_LINK, 0, 0);
    send_request(OP_APPEND, 0, 0);
    send_request(OP_APPEND, 1023, 4095);
    send_request(OP_APPEND, 0, 0);
    send_request(OP_HEAD, 0, 0);
    send_request(OP_HEAD, 1023, 0);
    send_request(OP_LINK, 0, 0);
    send_request(OP_LINK, 0, 2);
    send_request(OP_LINK, 0, 4095);
    write_groups(2047);
    send_request(OP_APPEND, 1023, 0);
    send_request(OP_HEAD, 512, 0);
    write_groups(1);
    send_request(OP_APPEND, 1, 0);
    send_request(OP_HEAD, 1023, 0);
    send_request(OP_APPEND, 0, 0);
    write_groups(0);
    send_request(OP_APPEND, 0, 0);
    send_request(OP_HEAD, 0, 0);
    send_request(OP_LINK, 0, 1);
    send_request(OP_CLEAR, 0, 0);
    send_request(OP_LINK, 0, 0);
    send_request(OP_HEAD, 0, 0);
    write_groups(1);
    send_request(OP_HEAD, 0, 0);
    send_request(OP_APPEND, 0, 0);
    send_request(OP_APPEND, 0, 0);
    send_request(OP_APPEND, 1, 0);
    send_request(OP_HEAD, 0, 0);
    send_request(OP_LINK, 0, 4094);
    send_request(OP_LINK, 0, 4095);
    write_groups(2047);
    send_request(OP_APPEND, 5, 0);
    send_request(OP_HEAD, 5, 0);
    send_request(OP_CLEAR, 0, 0);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_groups($urandom_range(1, 12));
        1: write_groups(1024);
        2: write_groups($urandom_range(1, 1023));
        default: write_groups(2047);
      endcase
      for (n = 0; n < 105; n++) random_request();
    end

    drain();
    repeat (30) @(posedge clk);
    if (fault_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bclb_pkg.sv
src/bclb_ram.sv
src/bclb_seq.sv
src/bucket_chain_link_builder.sv
tb/sv/bclb_chain_checker.sv
tb/sv/testbench.sv
